// ----- src/pid_controller_antiwindup_assert.svh -----
// assertion macros used by the pid controller checker
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PIDC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pidc_pkg.sv -----
// types and constants of the pid controller
`default_nettype none

package pidc_pkg;

	localparam int GAIN_W      = 16;
	localparam int DRIVE_W     = 8;
	localparam int FRAC_W      = 8;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_I_GAIN    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DRIVE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIVE = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_WITHIN = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MAX    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MIN    = 2'd2;

	// added to a negative Q43.8 sum so the shift truncates toward zero
	localparam logic [FRAC_W-1:0] ROUND_BIAS = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GUARD,
		ST_GUARD_CHK,
		ST_INTEG,
		ST_MUL_I,
		ST_ACC_I,
		ST_WAIT_DIV,
		ST_MUL_D,
		ST_ACC_D,
		ST_SCALE,
		ST_OUT
	} pidc_state_t;

	typedef struct packed {
		logic start;
		logic negative;
	} div_ctrl_t;

endpackage

`default_nettype wire

// ----- src/pidc_if.sv -----
// valid/ready channels for sample items and drive items
`default_nettype none

interface pidc_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 16
);
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic signed [SAMPLE_WIDTH-1:0] measured;
	logic signed [SAMPLE_WIDTH-1:0] setpoint;
	logic [TIME_WIDTH-1:0]          elapsed_ms;

	modport source (output valid, command, measured, setpoint, elapsed_ms, input ready);
	modport sink (input valid, command, measured, setpoint, elapsed_ms, output ready);
endinterface

interface pidc_out_if;
	logic                           valid;
	logic                           ready;
	logic [pidc_pkg::DRIVE_W-1:0]   drive;
	logic [pidc_pkg::STATUS_W-1:0]  clamp_status;

	modport source (output valid, drive, clamp_status, input ready);
	modport sink (input valid, drive, clamp_status, output ready);
endinterface

`default_nettype wire

// ----- src/pid_controller_antiwindup.sv -----
// discrete pid controller with anti-windup, one shared multiplier under a sequencer
//
// usage
//  - sample_in carries items of command, measured, setpoint and elapsed_ms; an item
//    is taken when valid and ready are both high at a rising clock edge
//  - a clear item (command high) zeroes the integral and the previous error in the
//    cycle it is taken and gives no result; ready stays high after it
//  - a compute item gives one drive item on drive_out: the drive value and a clamp
//    status (within range, clamped to max, clamped to min)
//  - the serial divider for the derivative, one quotient bit per cycle, starts in the
//    guard state and runs while the multiplier does three of its four products
//    alongside; the fourth, the d term, waits for the quotient
//  - ready is low from a compute item until its result sits in the output register
//  - the output register holds one result; if the receiver stalls, the next result
//    waits in the sequencer and sample_in stays not ready until the slot frees
//  - the user is to write gains and drive limits through cfg_we / cfg_index / cfg_data
//    while the block is idle, unchecked by the block; writes to unused indexes are dropped
//  - reset (arst_n low) clears the gains, the limits, the integral, the previous
//    error and any pending result
`default_nettype none

module pid_controller_antiwindup #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int TIME_WIDTH     = 16,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
	pidc_in_if.sink                                sample_in,
	pidc_out_if.source                             drive_out
);

	// error is one bit wider than a sample, error difference two bits wider
	localparam int EW = SAMPLE_WIDTH + 1;
	localparam int DW = SAMPLE_WIDTH + 2;
	localparam int MW = SAMPLE_WIDTH + 1;
	localparam int IW = INTEGRAL_WIDTH;
	localparam int GW = pidc_pkg::GAIN_W;
	// multiplier operand a takes a gain or the elapsed time, operand b the rest
	localparam int AW = (TIME_WIDTH + 1 > GW + 1) ? TIME_WIDTH + 1 : GW + 1;
	localparam int BW = (IW > DW) ? IW : DW;
	localparam int PW = AW + BW;
	localparam int CW = PW + 2;
	localparam int RW = CW - pidc_pkg::FRAC_W;
	localparam int DRW = pidc_pkg::DRIVE_W;

	localparam logic signed [IW-1:0]   INT_MAX     = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0]   INT_MIN     = {1'b1, {(IW-1){1'b0}}};
	localparam logic signed [IW+1:0]   INT_MAX_EXT = (IW+2)'(INT_MAX);
	localparam logic signed [IW+1:0]   INT_MIN_EXT = (IW+2)'(INT_MIN);

	// configuration registers
	logic [GW-1:0]  p_gain_q;
	logic [GW-1:0]  i_gain_q;
	logic [GW-1:0]  d_gain_q;
	logic [DRW-1:0] min_drive_q;
	logic [DRW-1:0] max_drive_q;

	pidc_pkg::pidc_state_t state_q, state_d;

	// sample registers and controller state
	logic signed [EW-1:0] err_q;
	logic signed [EW-1:0] prev_err_q;
	logic [TIME_WIDTH-1:0] t_q;
	logic signed [DW-1:0] diff_q;
	logic signed [IW-1:0] integral_q;
	logic                 guard_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CW-1:0] acc_q;
	logic signed [RW-1:0] res_q;

	// output register
	logic            out_valid_q;
	logic [DRW-1:0]  drive_q;
	logic [pidc_pkg::STATUS_W-1:0] status_q;

	// control from the sequencer
	logic in_ready;
	logic accept;
	logic out_free;
	logic ld_sample;
	logic ld_clear;
	logic ld_guard;
	logic ld_integ;
	logic acc_add;
	logic ld_res;
	logic ld_out;
	pidc_pkg::div_ctrl_t div_ctrl;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;

	// datapath helpers
	logic signed [EW-1:0] err_new;
	logic signed [EW-1:0] err_neg;
	logic [EW-1:0]        err_mag;
	logic signed [DW-1:0] diff_neg;
	logic [MW-1:0]        diff_mag;
	logic signed [DW-1:0] deriv;
	logic                 div_done;
	logic signed [PW-1:0] guard_thr;
	logic signed [IW+1:0] int_ext;
	logic signed [IW+1:0] add_mag;
	logic signed [IW+1:0] int_sum;
	logic                 int_sat;
	logic signed [IW-1:0] int_next;
	logic signed [CW-1:0] acc_bias;
	logic signed [CW-1:0] acc_round;
	logic signed [RW-1:0] max_ext;
	logic signed [RW-1:0] min_ext;
	logic [DRW-1:0]       drive_d;
	logic [pidc_pkg::STATUS_W-1:0] status_d;

	assign accept   = sample_in.valid && in_ready;
	assign out_free = !out_valid_q || drive_out.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q    <= '0;
			i_gain_q    <= '0;
			d_gain_q    <= '0;
			min_drive_q <= '0;
			max_drive_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pidc_pkg::REG_P_GAIN:    p_gain_q    <= cfg_data[GW-1:0];
				pidc_pkg::REG_I_GAIN:    i_gain_q    <= cfg_data[GW-1:0];
				pidc_pkg::REG_D_GAIN:    d_gain_q    <= cfg_data[GW-1:0];
				pidc_pkg::REG_MIN_DRIVE: min_drive_q <= cfg_data[DRW-1:0];
				pidc_pkg::REG_MAX_DRIVE: max_drive_q <= cfg_data[DRW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidc_pkg::ST_IDLE: begin
				if (accept && sample_in.command == pidc_pkg::CMD_COMPUTE) begin
					state_d = pidc_pkg::ST_GUARD;
				end
			end
			pidc_pkg::ST_GUARD:     state_d = pidc_pkg::ST_GUARD_CHK;
			pidc_pkg::ST_GUARD_CHK: state_d = pidc_pkg::ST_INTEG;
			pidc_pkg::ST_INTEG:     state_d = pidc_pkg::ST_MUL_I;
			pidc_pkg::ST_MUL_I:     state_d = pidc_pkg::ST_ACC_I;
			pidc_pkg::ST_ACC_I:     state_d = pidc_pkg::ST_WAIT_DIV;
			pidc_pkg::ST_WAIT_DIV: begin
				if (div_done) begin
					state_d = pidc_pkg::ST_MUL_D;
				end
			end
			pidc_pkg::ST_MUL_D:     state_d = pidc_pkg::ST_ACC_D;
			pidc_pkg::ST_ACC_D:     state_d = pidc_pkg::ST_SCALE;
			pidc_pkg::ST_SCALE:     state_d = pidc_pkg::ST_OUT;
			pidc_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = pidc_pkg::ST_IDLE;
				end
			end
			default: state_d = pidc_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs and multiplier operand selection
	always_comb begin
		in_ready          = 1'b0;
		ld_sample         = 1'b0;
		ld_clear          = 1'b0;
		ld_guard          = 1'b0;
		ld_integ          = 1'b0;
		acc_add           = 1'b0;
		ld_res            = 1'b0;
		ld_out            = 1'b0;
		div_ctrl.start    = 1'b0;
		div_ctrl.negative = diff_q[DW-1];
		mul_a             = '0;
		mul_b             = '0;
		case (state_q)
			pidc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ld_sample = accept && (sample_in.command == pidc_pkg::CMD_COMPUTE);
				ld_clear  = accept && (sample_in.command == pidc_pkg::CMD_CLEAR);
			end
			pidc_pkg::ST_GUARD: begin
				// p term, also the windup test
				mul_a          = AW'(p_gain_q);
				mul_b          = BW'(err_q);
				div_ctrl.start = 1'b1;
			end
			pidc_pkg::ST_GUARD_CHK: begin
				// error magnitude times elapsed for the integral
				ld_guard = 1'b1;
				mul_a    = AW'(t_q);
				mul_b    = BW'(err_mag);
			end
			pidc_pkg::ST_INTEG: begin
				ld_integ = 1'b1;
			end
			pidc_pkg::ST_MUL_I: begin
				mul_a = AW'(i_gain_q);
				mul_b = BW'(integral_q);
			end
			pidc_pkg::ST_ACC_I: begin
				acc_add = 1'b1;
			end
			pidc_pkg::ST_WAIT_DIV: ;
			pidc_pkg::ST_MUL_D: begin
				mul_a = AW'(d_gain_q);
				mul_b = BW'(deriv);
			end
			pidc_pkg::ST_ACC_D: begin
				acc_add = 1'b1;
			end
			pidc_pkg::ST_SCALE: begin
				ld_res = 1'b1;
			end
			pidc_pkg::ST_OUT: begin
				ld_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// error and its difference from the previous sample
	assign err_new  = EW'(sample_in.setpoint) - EW'(sample_in.measured);
	assign err_neg  = -err_q;
	assign err_mag  = err_q[EW-1] ? err_neg : err_q;
	assign diff_neg = -diff_q;
	assign diff_mag = diff_q[DW-1] ? diff_neg[MW-1:0] : diff_q[MW-1:0];

	always_ff @(posedge clk) begin
		if (ld_sample) begin
			err_q  <= err_new;
			t_q    <= sample_in.elapsed_ms;
			diff_q <= DW'(err_new) - DW'(prev_err_q);
		end
	end

	// the one shared multiplier, product registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// windup guard: p_gain * error below max_drive in Q8.8
	assign guard_thr = PW'({max_drive_q, pidc_pkg::FRAC_W'(0)});

	// integral update with saturation at the signed integral range
	assign int_sat = |prod_q[PW-1:IW];
	assign int_ext = (IW+2)'(integral_q);
	assign add_mag = (IW+2)'(prod_q[IW-1:0]);
	assign int_sum = err_q[EW-1] ? (int_ext - add_mag) : (int_ext + add_mag);

	always_comb begin
		if (int_sat) begin
			int_next = err_q[EW-1] ? INT_MIN : INT_MAX;
		end else if (int_sum > INT_MAX_EXT) begin
			int_next = INT_MAX;
		end else if (int_sum < INT_MIN_EXT) begin
			int_next = INT_MIN;
		end else begin
			int_next = int_sum[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integral_q <= '0;
		end else if (ld_clear) begin
			prev_err_q <= '0;
			integral_q <= '0;
		end else begin
			if (ld_sample) begin
				prev_err_q <= err_new;
			end
			if (ld_integ && guard_q) begin
				integral_q <= int_next;
			end
		end
	end

	// accumulate the three terms in Q43.8
	always_ff @(posedge clk) begin
		if (ld_guard) begin
			guard_q <= (prod_q < guard_thr);
			acc_q   <= CW'(prod_q);
		end else if (acc_add) begin
			acc_q <= acc_q + CW'(prod_q);
		end
	end

	// derivative divider
	pidc_div #(
		.NUM_W (MW),
		.DEN_W (TIME_WIDTH)
	) u_pidc_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.num    (diff_mag),
		.den    (t_q),
		.quot   (deriv),
		.done   (div_done)
	);

	// drop the fraction, truncating toward zero
	assign acc_bias  = acc_q[CW-1] ? CW'(pidc_pkg::ROUND_BIAS) : '0;
	assign acc_round = acc_q + acc_bias;

	always_ff @(posedge clk) begin
		if (ld_res) begin
			res_q <= acc_round[CW-1:pidc_pkg::FRAC_W];
		end
	end

	// clamp: max first, then min
	assign max_ext = RW'(max_drive_q);
	assign min_ext = RW'(min_drive_q);

	always_comb begin
		if (res_q > max_ext) begin
			drive_d  = max_drive_q;
			status_d = pidc_pkg::STATUS_MAX;
		end else if (res_q < min_ext) begin
			drive_d  = min_drive_q;
			status_d = pidc_pkg::STATUS_MIN;
		end else begin
			drive_d  = res_q[DRW-1:0];
			status_d = pidc_pkg::STATUS_WITHIN;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (drive_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			drive_q  <= drive_d;
			status_q <= status_d;
		end
	end

	assign sample_in.ready        = in_ready;
	assign drive_out.valid        = out_valid_q;
	assign drive_out.drive        = drive_q;
	assign drive_out.clamp_status = status_q;

endmodule

`default_nettype wire

// ----- src/pidc_div.sv -----
// restoring serial divider, one quotient bit per cycle, signed result
`default_nettype none

module pidc_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pidc_pkg::div_ctrl_t ctrl,
	input  wire logic [NUM_W-1:0]    num,
	input  wire logic [DEN_W-1:0]    den,
	output logic signed [NUM_W:0]    quot,
	output logic                     done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic               busy_q;
	logic               fix_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   work_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic               zero_q;
	logic signed [NUM_W:0] quot_q;

	logic [DEN_W:0]     shifted;
	logic [DEN_W:0]     den_ext;
	logic [DEN_W:0]     trial;
	logic               ge;
	logic signed [NUM_W:0] mag_ext;

	assign shifted = {rem_q, work_q[NUM_W-1]};
	assign den_ext = {1'b0, den_q};
	assign trial   = shifted - den_ext;
	assign ge      = (shifted >= den_ext);
	assign mag_ext = {1'b0, work_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end
		end else if (fix_q) begin
			fix_q  <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= ctrl.negative;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end else if (fix_q) begin
			// zero divisor gives a zero derivative
			if (zero_q) begin
				quot_q <= '0;
			end else if (neg_q) begin
				quot_q <= -mag_ext;
			end else begin
				quot_q <= mag_ext;
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ----- src/pidc_checker.sv -----
// port-level checks of the pid controller, bound to the top level
`default_nettype none

`include "pid_controller_antiwindup_assert.svh"

module pidc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              in_command,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [pidc_pkg::DRIVE_W-1:0]      drive,
	input wire logic [pidc_pkg::STATUS_W-1:0]     clamp_status,
	input wire logic                              cfg_we,
	input wire logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input wire logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// shadow copies of the drive limits, seen from the write port
	logic [pidc_pkg::DRIVE_W-1:0] min_sh_q;
	logic [pidc_pkg::DRIVE_W-1:0] max_sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sh_q <= '0;
			max_sh_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == pidc_pkg::REG_MIN_DRIVE) begin
				min_sh_q <= cfg_data[pidc_pkg::DRIVE_W-1:0];
			end
			if (cfg_index == pidc_pkg::REG_MAX_DRIVE) begin
				max_sh_q <= cfg_data[pidc_pkg::DRIVE_W-1:0];
			end
		end
	end

	`PIDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(clamp_status), "drive item changed while stalled")
	`PIDC_ASSERT_SAME(a_clamp_max, out_valid && clamp_status == pidc_pkg::STATUS_MAX, drive == max_sh_q, "max clamp does not give max_drive")
	`PIDC_ASSERT_SAME(a_clamp_min, out_valid && clamp_status == pidc_pkg::STATUS_MIN, drive == min_sh_q, "min clamp does not give min_drive")
	`PIDC_ASSERT_SAME(a_within, out_valid && clamp_status == pidc_pkg::STATUS_WITHIN, drive <= max_sh_q && drive >= min_sh_q, "unclamped drive outside limits")
	`PIDC_ASSERT_NEXT(a_busy, in_valid && in_ready && in_command == pidc_pkg::CMD_COMPUTE, !in_ready, "ready after a compute item")

endmodule

bind pid_controller_antiwindup pidc_checker u_pidc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_in.valid),
	.in_ready     (sample_in.ready),
	.in_command   (sample_in.command),
	.out_valid    (drive_out.valid),
	.out_ready    (drive_out.ready),
	.drive        (drive_out.drive),
	.clamp_status (drive_out.clamp_status),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

`default_nettype wire

// ----- tb/sv/tb_pid_controller_antiwindup.sv -----
// self-checking testbench of the pid controller: directed table, then random samples
module tb_pid_controller_antiwindup;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	localparam int SAMPLE_W        = 16;
	localparam int TIME_W          = 16;
	// time from a compute item being taken to its result showing valid
	localparam int RESULT_LATENCY  = SAMPLE_W + 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int LONG_HOLD       = 200;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 72;

	localparam longint INTEG_MAX   = 64'sd2147483647;
	localparam longint INTEG_MIN   = -64'sd2147483648;
	localparam longint PRODUCT_CAP = 64'sd4294967296;

	typedef struct {
		logic                       command;
		logic signed [SAMPLE_W-1:0] measured;
		logic signed [SAMPLE_W-1:0] setpoint;
		logic [TIME_W-1:0]          elapsed_ms;
	} sample_t;

	typedef struct {
		logic [DRIVE_W-1:0]  drive;
		logic [STATUS_W-1:0] clamp_status;
	} drive_item_t;

	typedef enum {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

	// one line of the directed table: either a new register set or a sample item
	typedef struct {
		row_kind_t          kind;
		sample_t            sample;
		logic [GAIN_W-1:0]  gp, gi, gd;
		logic [DRIVE_W-1:0] lo, hi;
		bit                 typed;
		drive_item_t        want;
	} row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	pidc_in_if #(.SAMPLE_WIDTH(SAMPLE_W), .TIME_WIDTH(TIME_W)) sample_ch ();
	pidc_out_if drive_ch ();

	pid_controller_antiwindup #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.TIME_WIDTH(TIME_W),
		.INTEGRAL_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_in(sample_ch),
		.drive_out(drive_ch)
	);

	// mirror of the controller registers and state
	logic [GAIN_W-1:0]  gain_p   = '0;
	logic [GAIN_W-1:0]  gain_i   = '0;
	logic [GAIN_W-1:0]  gain_d   = '0;
	logic [DRIVE_W-1:0] drive_lo = '0;
	logic [DRIVE_W-1:0] drive_hi = '0;
	longint             err_last  = 0;
	longint             integ_acc = 0;

	drive_item_t  pending_drives[$];
	row_t         directed[$];
	int           mismatches   = 0;
	int unsigned  cycles       = 0;
	bit           quiet        = 1'b0;
	bit           hold_off_req = 1'b0;
	bit           offering     = 1'b0;

	always #1 clk = ~clk;

	// next drive item for one sample item; returns 0 for a clear, which gives none
	function automatic bit compute_drive(input sample_t s, output drive_item_t r);
		longint err, mag, prod, acc, deriv, total, res;
		r.drive        = '0;
		r.clamp_status = STATUS_WITHIN;
		if (s.command == CMD_CLEAR) begin
			err_last  = 0;
			integ_acc = 0;
			return 1'b0;
		end
		err = longint'(s.setpoint) - longint'(s.measured);
		// anti-windup: integrate only while the proportional part is under the top limit
		if (longint'(gain_p) * err < longint'(drive_hi) * 256) begin
			mag  = (err < 0) ? -err : err;
			prod = mag * longint'(s.elapsed_ms);
			if (prod > PRODUCT_CAP) begin
				integ_acc = (err < 0) ? INTEG_MIN : INTEG_MAX;
			end else begin
				acc = integ_acc + ((err < 0) ? -prod : prod);
				integ_acc = (acc > INTEG_MAX) ? INTEG_MAX : (acc < INTEG_MIN) ? INTEG_MIN : acc;
			end
		end
		// signed division truncates toward zero; no time elapsed means no slope
		deriv    = (s.elapsed_ms == 0) ? 0 : (err - err_last) / longint'(s.elapsed_ms);
		err_last = err;
		total = longint'(gain_p) * err + longint'(gain_i) * integ_acc
			+ longint'(gain_d) * deriv;
		res = total / 256;
		// top limit is tested first, so crossed limits fall to the bottom one
		if (res > longint'(drive_hi)) begin
			r.drive        = drive_hi;
			r.clamp_status = STATUS_MAX;
		end else if (res < longint'(drive_lo)) begin
			r.drive        = drive_lo;
			r.clamp_status = STATUS_MIN;
		end else begin
			r.drive = res[DRIVE_W-1:0];
		end
		return 1'b1;
	endfunction

	function automatic void add_config(input logic [GAIN_W-1:0] p, i, d,
			input logic [DRIVE_W-1:0] lo, hi);
		row_t row;
		row      = '{kind: ROW_CONFIG, default: '0};
		row.gp   = p;
		row.gi   = i;
		row.gd   = d;
		row.lo   = lo;
		row.hi   = hi;
		directed.push_back(row);
	endfunction

	function automatic void add_sample(input logic cmd, input int meas, set, elapsed,
			input bit typed = 1'b0, input logic [DRIVE_W-1:0] drv = '0,
			input logic [STATUS_W-1:0] st = STATUS_WITHIN);
		row_t row;
		row                   = '{kind: ROW_SAMPLE, default: '0};
		row.sample.command    = cmd;
		row.sample.measured   = meas[SAMPLE_W-1:0];
		row.sample.setpoint   = set[SAMPLE_W-1:0];
		row.sample.elapsed_ms = elapsed[TIME_W-1:0];
		row.typed             = typed;
		row.want.drive        = drv;
		row.want.clamp_status = st;
		directed.push_back(row);
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int base, delta, target;
		s.command = ($urandom_range(0, 11) == 0) ? CMD_CLEAR : CMD_COMPUTE;
		if ($urandom_range(0, 9) < 7) begin
			// setpoint close to the reading, so the output is not always pinned
			base   = $urandom_range(0, 65535) - 32768;
			delta  = $urandom_range(0, 1023) - 512;
			target = base + delta;
			if (target > 32767)
				target = 32767;
			if (target < -32768)
				target = -32768;
			s.measured = base[SAMPLE_W-1:0];
			s.setpoint = target[SAMPLE_W-1:0];
		end else begin
			s.measured = SAMPLE_W'($urandom);
			s.setpoint = SAMPLE_W'($urandom);
		end
		s.elapsed_ms = ($urandom_range(0, 4) != 0) ? TIME_W'($urandom_range(0, 50))
			: TIME_W'($urandom_range(0, 65535));
		return s;
	endfunction

	// drop valid, called only in the step at which the last item was taken
	task automatic stop_offering();
		if (offering) begin
			sample_ch.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic push_sample(input sample_t s, input bit typed, input drive_item_t want);
		drive_item_t predicted;
		sample_ch.valid      <= 1'b1;
		offering = 1'b1;
		sample_ch.command    <= s.command;
		sample_ch.measured   <= s.measured;
		sample_ch.setpoint   <= s.setpoint;
		sample_ch.elapsed_ms <= s.elapsed_ms;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		// item taken at this edge
		if (compute_drive(s, predicted))
			pending_drives.push_back(typed ? want : predicted);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			stop_offering();
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic apply_settings(input logic [GAIN_W-1:0] p, i, d,
			input logic [DRIVE_W-1:0] lo, hi);
		// only while idle: nothing in flight, then a margin on top of the result latency
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_P_GAIN;
		cfg_data  <= p;
		@(posedge clk);
		cfg_index <= REG_I_GAIN;
		cfg_data  <= i;
		@(posedge clk);
		cfg_index <= REG_D_GAIN;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= REG_MIN_DRIVE;
		cfg_data  <= CFG_DATA_W'(lo);
		@(posedge clk);
		cfg_index <= REG_MAX_DRIVE;
		cfg_data  <= CFG_DATA_W'(hi);
		@(posedge clk);
		cfg_we   <= 1'b0;
		gain_p   = p;
		gain_i   = i;
		gain_d   = d;
		drive_lo = lo;
		drive_hi = hi;
	endtask

	// receiver: checks each drive item, stalls in bursts, and once holds off for long
	initial begin
		drive_item_t want;
		int gap;
		gap = 0;
		drive_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (drive_ch.valid && drive_ch.ready) begin
				if (pending_drives.size() == 0) begin
					$error("drive item arrived with no sample waiting for it");
					mismatches++;
				end else begin
					want = pending_drives.pop_front();
					if (drive_ch.drive !== want.drive) begin
						$error("drive: expected %0d, got %0d", want.drive, drive_ch.drive);
						mismatches++;
					end
					if (drive_ch.clamp_status !== want.clamp_status) begin
						$error("clamp_status: expected %0d, got %0d",
							want.clamp_status, drive_ch.clamp_status);
						mismatches++;
					end
				end
			end
			if (hold_off_req) begin
				// long hold-off: output register and sequencer fill, input stalls
				hold_off_req = 1'b0;
				drive_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (gap > 0) begin
				gap--;
				drive_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(0, 11);
				drive_ch.ready <= 1'b0;
			end else begin
				drive_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		row_t row;
		drive_item_t none;
		logic [GAIN_W-1:0] p, i, d;
		logic [DRIVE_W-1:0] lo, hi;
		none.drive           = '0;
		none.clamp_status    = STATUS_WITHIN;
		sample_ch.valid      = 1'b0;
		sample_ch.command    = CMD_COMPUTE;
		sample_ch.measured   = '0;
		sample_ch.setpoint   = '0;
		sample_ch.elapsed_ms = '0;

		// registers as reset: every gain zero, the output sits at zero
		add_sample(CMD_COMPUTE, -32768, 32767, 65535, 1'b1, 8'd0, STATUS_WITHIN);
		add_sample(CMD_COMPUTE, 32767, -32768, 0, 1'b1, 8'd0, STATUS_WITHIN);
		add_sample(CMD_CLEAR, 0, 0, 0);
		// unity proportional gain on a 50..200 range: inside, above, below
		add_config(16'h0100, 16'h0000, 16'h0000, 8'd50, 8'd200);
		add_sample(CMD_COMPUTE, 0, 100, 10, 1'b1, 8'd100, STATUS_WITHIN);
		add_sample(CMD_COMPUTE, 0, 1000, 10, 1'b1, 8'd200, STATUS_MAX);
		add_sample(CMD_COMPUTE, 5, 0, 10, 1'b1, 8'd50, STATUS_MIN);
		add_sample(CMD_COMPUTE, 7, 7, 0, 1'b1, 8'd50, STATUS_MIN);
		// crossed limits: the top test wins, anything else goes to the bottom limit
		add_config(16'h0100, 16'h0000, 16'h0000, 8'd200, 8'd100);
		add_sample(CMD_COMPUTE, 0, 150, 1, 1'b1, 8'd100, STATUS_MAX);
		add_sample(CMD_COMPUTE, 0, 50, 1, 1'b1, 8'd200, STATUS_MIN);
		// integral alone at full error span, driven into saturation both ways
		add_config(16'h0000, 16'h0001, 16'h0000, 8'd0, 8'd255);
		add_sample(CMD_COMPUTE, -32768, 32767, 65535);
		add_sample(CMD_COMPUTE, -32768, 32767, 65535);
		add_sample(CMD_COMPUTE, -32768, 32767, 65535);
		add_sample(CMD_COMPUTE, 32767, -32768, 65535);
		add_sample(CMD_COMPUTE, 32767, -32768, 65535);
		add_sample(CMD_CLEAR, 0, 0, 0);
		// derivative alone: zero elapsed time, negative slope, truncation toward zero
		add_config(16'h0000, 16'h0000, 16'h0100, 8'd0, 8'd255);
		add_sample(CMD_COMPUTE, 0, 1000, 0, 1'b1, 8'd0, STATUS_WITHIN);
		add_sample(CMD_COMPUTE, 1000, 0, 3);
		add_sample(CMD_COMPUTE, 0, 1000, 7);
		add_sample(CMD_COMPUTE, 1, 1000, 2);
		// every gain at its top
		add_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255);
		add_sample(CMD_COMPUTE, -32768, 32767, 1);
		add_sample(CMD_COMPUTE, 32767, -32768, 65535);
		add_sample(CMD_COMPUTE, 0, 0, 65535);
		// top limit zero: the windup guard stays shut even at zero error
		add_config(16'h0000, 16'h0100, 16'h0000, 8'd0, 8'd0);
		add_sample(CMD_COMPUTE, 4, 4, 5);
		add_sample(CMD_COMPUTE, 0, 3, 2);
		add_sample(CMD_CLEAR, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[k]) begin
			row = directed[k];
			if (row.kind == ROW_CONFIG) begin
				stop_offering();
				apply_settings(row.gp, row.gi, row.gd, row.lo, row.hi);
			end else begin
				push_sample(row.sample, row.typed, row.want);
			end
		end

		// random phases, each under its own register set
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			stop_offering();
			case (ph)
				0: begin
					p  = '1;
					i  = '1;
					d  = '1;
					lo = '0;
					hi = '1;
				end
				1: begin
					p  = '0;
					i  = '0;
					d  = '0;
					lo = '0;
					hi = '0;
				end
				default: begin
					p  = GAIN_W'($urandom_range(0, 16'h0800));
					i  = GAIN_W'($urandom_range(0, 8));
					d  = GAIN_W'($urandom_range(0, 16'h0800));
					lo = DRIVE_W'($urandom_range(0, 60));
					hi = DRIVE_W'($urandom_range(100, 255));
					// now and then any limits at all, crossed ones included
					if ($urandom_range(0, 5) == 0) begin
						lo = DRIVE_W'($urandom);
						hi = DRIVE_W'($urandom);
					end
				end
			endcase
			apply_settings(p, i, d, lo, hi);
			if (ph == 2)
				hold_off_req = 1'b1;
			// last stretch runs flat out on both sides
			if (ph == RANDOM_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				push_sample(random_sample(), 1'b0, none);
		end

		stop_offering();
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/pidc_pkg.sv
src/pidc_if.sv
src/pidc_div.sv
src/pid_controller_antiwindup.sv
src/pidc_checker.sv
tb/sv/tb_pid_controller_antiwindup.sv
